// ===== rtl/core/grc_pkg.sv =====
// Shared types and constants of the grid raycast column renderer.
// Depends on nothing; the core, the checker and the testbench use it.
package grc_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANG_MUL,
		ST_ANG_DIV,
		ST_ANG_WAIT,
		ST_SIN_ZZ,
		ST_SIN_T,
		ST_SIN_U,
		ST_SIN_V,
		ST_SIN_END,
		ST_STEP_X,
		ST_STEP_Y,
		ST_INIT,
		ST_PROBE,
		ST_LOOK,
		ST_E_VEC,
		ST_E_XX,
		ST_E_YY,
		ST_E_DX,
		ST_E_DY,
		ST_E_DOT,
		ST_E_SQ,
		ST_E_CL,
		ST_E_CMP,
		ST_WH_DIV,
		ST_WH_WAIT,
		ST_PITCH,
		ST_TOP,
		ST_EMIT
	} state_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_FIELD_OF_VIEW = 3'd2;
	localparam logic [2:0] CFG_MAX_DEPTH     = 3'd3;
	localparam logic [2:0] CFG_MARCH_STEP    = 3'd4;
	localparam logic [2:0] CFG_MAP_WIDTH     = 3'd5;
	localparam logic [2:0] CFG_MAP_HEIGHT    = 3'd6;
	localparam logic [2:0] CFG_EDGE_COSINE   = 3'd7;

	localparam logic [8:0]  RST_SCREEN_WIDTH  = 9'd120;
	localparam logic [6:0]  RST_SCREEN_HEIGHT = 7'd40;
	localparam logic [15:0] RST_FIELD_OF_VIEW = 16'd16384;
	localparam logic [15:0] RST_MAX_DEPTH     = 16'd16384;
	localparam logic [10:0] RST_MARCH_STEP    = 11'd102;
	localparam logic [6:0]  RST_MAP_WIDTH     = 7'd50;
	localparam logic [6:0]  RST_MAP_HEIGHT    = 7'd50;
	localparam logic [15:0] RST_EDGE_COSINE   = 16'd65533;

	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [14:0] SIN_B = 15'd10512;
	localparam logic [23:0] SIN_C = 24'd1160;
	localparam logic [14:0] QUARTER = 15'd16384;

	localparam logic [15:0] GL_FULL   = 16'h2588;
	localparam logic [15:0] GL_DARK   = 16'h2593;
	localparam logic [15:0] GL_MEDIUM = 16'h2592;
	localparam logic [15:0] GL_LIGHT  = 16'h2591;
	localparam logic [15:0] GL_BLANK  = 16'h0020;
	localparam logic [15:0] GL_TILDE  = 16'h007E;
	localparam logic [15:0] GL_DASH   = 16'h002D;
	localparam logic [15:0] GL_DOT    = 16'h002E;
	localparam logic [15:0] GL_HASH   = 16'h0023;
	localparam logic [15:0] GL_CROSS  = 16'h0078;

endpackage

// ===== rtl/core/grc_if.sv =====
// Valid/ready channel interfaces of the grid raycast column renderer:
// the command channel and the glyph result channel. Depends on nothing.
interface grc_cmd_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [15:0]        player_x;
	logic [15:0]        player_y;
	logic [15:0]        view_angle;
	logic signed [15:0] view_pitch;
	logic [7:0]         column;
	logic [5:0]         cell_x;
	logic [5:0]         cell_y;
	logic               cell_is_wall;

	modport source (
		output valid, opcode, player_x, player_y, view_angle, view_pitch,
		output column, cell_x, cell_y, cell_is_wall,
		input ready
	);
	modport sink (
		input valid, opcode, player_x, player_y, view_angle, view_pitch,
		input column, cell_x, cell_y, cell_is_wall,
		output ready
	);
endinterface

interface grc_res_if;
	logic        valid;
	logic        ready;
	logic [5:0]  row;
	logic [15:0] glyph;
	logic        is_last;

	modport source (output valid, row, glyph, is_last, input ready);
	modport sink (input valid, row, glyph, is_last, output ready);
endinterface

// ===== rtl/core/grc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Stand-alone unit shared by the angle and wall-height divisions.
module grc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [16:0] divisor,
	output logic        busy,
	output logic [23:0] quotient
);
	logic [16:0] rem_q;
	logic [23:0] quo_q;
	logic [16:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q, quo_q[23]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd23;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/grc_isqrt.sv =====
// Floor integer square root, two radicand bits per cycle.
// Stand-alone unit used by the wall edge test.
module grc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [37:0] radicand,
	output logic        busy,
	output logic [18:0] root
);
	logic [37:0] x_q;
	logic [19:0] rem_q;
	logic [18:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [21:0] acc;
	logic [21:0] trial;
	logic [21:0] diff;

	assign acc   = {rem_q, x_q[37:36]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = acc - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd18;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[35:0], 2'b00};
			if (acc >= trial) begin
				rem_q  <= diff[19:0];
				root_q <= {root_q[17:0], 1'b1};
			end else begin
				rem_q  <= acc[19:0];
				root_q <= {root_q[17:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ===== rtl/core/grc_map.sv =====
// Wall map memory, one bit per cell, with a clearing pass after reset.
// Stand-alone; read data is registered.
module grc_map #(
	parameter int MAP_SIDE = 64,
	localparam int DEPTH = MAP_SIDE * MAP_SIDE,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_data,
	output logic          ready
);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic          mem [DEPTH];
	logic          clr_q;
	logic [AW-1:0] cnt_q;
	logic          rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			cnt_q <= cnt_q + AW'(1);
			if (cnt_q == LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[cnt_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !clr_q;
endmodule

// ===== rtl/core/grid_raycast_column_renderer_core.sv =====
// Grid raycast column renderer: a column cast runs on one shared 24x24 multiplier,
// a radix-2 divider and a square-root unit under a sequencer: fixed work of two
// divisions and two sine evaluations, a map memory read per march step, the
// four-corner edge test on a hit, and one row per cycle while the result side
// takes them. After reset the map memory is cleared before the first command.
module grid_raycast_column_renderer_core #(
	parameter int MAP_SIDE = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	grc_cmd_if.sink     cmd,
	grc_res_if.source   res
);
	localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);
	localparam logic [8:0] SIDE9 = 9'(MAP_SIDE);
	localparam logic [6:0] ROWS7 = 7'(MAX_ROWS);

	grc_pkg::state_t state_q, state_d;

	logic [8:0]  sw_q;
	logic [6:0]  sh_q;
	logic [15:0] fov_q;
	logic [15:0] maxd_q;
	logic [10:0] step_q;
	logic [6:0]  mw_q;
	logic [6:0]  mh_q;
	logic [15:0] ecos_q;

	logic [8:0]  w_eff;
	logic [10:0] stp;
	logic [8:0]  mw_eff;
	logic [8:0]  mh_eff;

	logic [15:0]        px_q, py_q, view_q;
	logic signed [15:0] pitch_q;
	logic [7:0]         col_q;
	logic [6:0]         h_q;
	logic [15:0]        ang_q;
	logic               phase_q;
	logic [14:0]        z_q, z2_q;
	logic signed [15:0] ex_q, ey_q;
	logic signed [27:0] dx_q, dy_q;
	logic [16:0]        d_q;
	logic signed [32:0] sx_q, sy_q;
	logic [7:0]         cx_q, cy_q;
	logic               edge_q;
	logic [1:0]         k_q;
	logic signed [19:0] vx_q, vy_q;
	logic [37:0]        acc_q;
	logic signed [35:0] dot_q;
	logic [16:0]        wh_q;
	logic signed [19:0] top_q, bot_q;
	logic signed [23:0] top13_q, top4_q;
	logic [15:0]        shade_q;
	logic [6:0]         y_q;

	logic               out_v_q;
	logic [5:0]         row_q;
	logic [15:0]        glyph_q;
	logic               last_q;

	logic signed [23:0] mul_a, mul_b;
	logic signed [47:0] mul_q;

	logic        div_start, div_busy;
	logic [23:0] div_dvd, div_quo;
	logic [16:0] div_dvs;
	logic        sq_start, sq_busy;
	logic [18:0] sq_root;

	logic          map_ready, map_rd_en, map_rd, map_wr_en;
	logic [AW-1:0] map_wr_addr, map_rd_addr;

	logic        accept;
	logic [15:0] a_ph;
	logic [14:0] z_cur, t_cur, u_cur;
	logic [15:0] v_cur;
	logic signed [15:0] sv_cur;
	logic        oob;
	logic [16:0] dd;
	logic        slot_free;
	logic [15:0] glyph_cur;
	logic signed [15:0] pitch_sat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= grc_pkg::RST_SCREEN_WIDTH;
			sh_q   <= grc_pkg::RST_SCREEN_HEIGHT;
			fov_q  <= grc_pkg::RST_FIELD_OF_VIEW;
			maxd_q <= grc_pkg::RST_MAX_DEPTH;
			step_q <= grc_pkg::RST_MARCH_STEP;
			mw_q   <= grc_pkg::RST_MAP_WIDTH;
			mh_q   <= grc_pkg::RST_MAP_HEIGHT;
			ecos_q <= grc_pkg::RST_EDGE_COSINE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				grc_pkg::CFG_SCREEN_WIDTH:  sw_q   <= cfg_data[8:0];
				grc_pkg::CFG_SCREEN_HEIGHT: sh_q   <= cfg_data[6:0];
				grc_pkg::CFG_FIELD_OF_VIEW: fov_q  <= cfg_data;
				grc_pkg::CFG_MAX_DEPTH:     maxd_q <= cfg_data;
				grc_pkg::CFG_MARCH_STEP:    step_q <= cfg_data[10:0];
				grc_pkg::CFG_MAP_WIDTH:     mw_q   <= cfg_data[6:0];
				grc_pkg::CFG_MAP_HEIGHT:    mh_q   <= cfg_data[6:0];
				grc_pkg::CFG_EDGE_COSINE:   ecos_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff  = (sw_q == 9'd0) ? 9'd1 : sw_q;
	assign stp    = (step_q == 11'd0) ? 11'd1 : step_q;
	assign mw_eff = ({2'b00, mw_q} > SIDE9) ? SIDE9 : {2'b00, mw_q};
	assign mh_eff = ({2'b00, mh_q} > SIDE9) ? SIDE9 : {2'b00, mh_q};

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == grc_pkg::ST_IDLE) && map_ready;

	assign pitch_sat = (cmd.view_pitch > 16'sd16384) ? 16'sd16384 :
		(cmd.view_pitch < -16'sd16384) ? -16'sd16384 : cmd.view_pitch;

	// sine datapath
	assign a_ph  = ang_q + (phase_q ? 16'h4000 : 16'h0000);
	assign z_cur = a_ph[14] ? (grc_pkg::QUARTER - {1'b0, a_ph[13:0]}) : {1'b0, a_ph[13:0]};
	assign t_cur = grc_pkg::SIN_B - mul_q[28:14];
	assign u_cur = grc_pkg::SIN_A - mul_q[28:14];
	assign v_cur = mul_q[29:14];
	assign sv_cur = a_ph[15] ? -$signed(v_cur) : $signed(v_cur);

	// march probe
	assign oob = sx_q[32] || sy_q[32] || ({1'b0, sx_q[31:24]} >= mw_eff)
		|| ({1'b0, sy_q[31:24]} >= mh_eff);
	assign map_rd_addr = AW'(sy_q[31:24] * MAP_SIDE + sx_q[31:24]);
	assign map_rd_en   = (state_q == grc_pkg::ST_PROBE) && !oob;
	assign map_wr_en   = accept && (cmd.opcode == grc_pkg::OP_WRITE)
		&& ({3'b000, cmd.cell_x} < SIDE9) && ({3'b000, cmd.cell_y} < SIDE9);
	assign map_wr_addr = AW'(cmd.cell_y * MAP_SIDE + cmd.cell_x);

	assign dd = (d_q == 17'd0) ? 17'd1 : d_q;

	grc_map #(.MAP_SIDE(MAP_SIDE)) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (cmd.cell_is_wall),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd),
		.ready   (map_ready)
	);

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	grc_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q + mul_q[37:0]),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grc_pkg::ST_IDLE:
				if (accept && cmd.opcode == grc_pkg::OP_CAST) state_d = grc_pkg::ST_ANG_MUL;
			grc_pkg::ST_ANG_MUL:  state_d = grc_pkg::ST_ANG_DIV;
			grc_pkg::ST_ANG_DIV:  state_d = grc_pkg::ST_ANG_WAIT;
			grc_pkg::ST_ANG_WAIT: if (!div_busy) state_d = grc_pkg::ST_SIN_ZZ;
			grc_pkg::ST_SIN_ZZ:   state_d = grc_pkg::ST_SIN_T;
			grc_pkg::ST_SIN_T:    state_d = grc_pkg::ST_SIN_U;
			grc_pkg::ST_SIN_U:    state_d = grc_pkg::ST_SIN_V;
			grc_pkg::ST_SIN_V:    state_d = grc_pkg::ST_SIN_END;
			grc_pkg::ST_SIN_END:
				state_d = phase_q ? grc_pkg::ST_STEP_X : grc_pkg::ST_SIN_ZZ;
			grc_pkg::ST_STEP_X:   state_d = grc_pkg::ST_STEP_Y;
			grc_pkg::ST_STEP_Y:   state_d = grc_pkg::ST_INIT;
			grc_pkg::ST_INIT:
				state_d = (maxd_q == 16'd0) ? grc_pkg::ST_WH_DIV : grc_pkg::ST_PROBE;
			grc_pkg::ST_PROBE:
				state_d = oob ? grc_pkg::ST_WH_DIV : grc_pkg::ST_LOOK;
			grc_pkg::ST_LOOK:
				if (map_rd) state_d = grc_pkg::ST_E_VEC;
				else if (d_q < {1'b0, maxd_q}) state_d = grc_pkg::ST_PROBE;
				else state_d = grc_pkg::ST_WH_DIV;
			grc_pkg::ST_E_VEC:    state_d = grc_pkg::ST_E_XX;
			grc_pkg::ST_E_XX:     state_d = grc_pkg::ST_E_YY;
			grc_pkg::ST_E_YY:     state_d = grc_pkg::ST_E_DX;
			grc_pkg::ST_E_DX:     state_d = grc_pkg::ST_E_DY;
			grc_pkg::ST_E_DY:     state_d = grc_pkg::ST_E_DOT;
			grc_pkg::ST_E_DOT:    state_d = grc_pkg::ST_E_SQ;
			grc_pkg::ST_E_SQ:     if (!sq_busy) state_d = grc_pkg::ST_E_CL;
			grc_pkg::ST_E_CL:     state_d = grc_pkg::ST_E_CMP;
			grc_pkg::ST_E_CMP:
				state_d = (k_q == 2'd3) ? grc_pkg::ST_WH_DIV : grc_pkg::ST_E_VEC;
			grc_pkg::ST_WH_DIV:   state_d = grc_pkg::ST_WH_WAIT;
			grc_pkg::ST_WH_WAIT:  if (!div_busy) state_d = grc_pkg::ST_PITCH;
			grc_pkg::ST_PITCH:    state_d = grc_pkg::ST_TOP;
			grc_pkg::ST_TOP:
				state_d = (h_q == 7'd0) ? grc_pkg::ST_IDLE : grc_pkg::ST_EMIT;
			grc_pkg::ST_EMIT:
				if (slot_free && y_q == h_q - 7'd1) state_d = grc_pkg::ST_IDLE;
			default: state_d = grc_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = {16'd0, fov_q[7:0]};
		div_dvs   = {8'd0, w_eff};
		sq_start  = 1'b0;
		unique case (state_q)
			grc_pkg::ST_ANG_MUL: begin
				mul_a = {8'd0, fov_q};
				mul_b = {16'd0, col_q};
			end
			grc_pkg::ST_ANG_DIV: begin
				div_start = 1'b1;
				div_dvd   = mul_q[23:0];
				div_dvs   = {8'd0, w_eff};
			end
			grc_pkg::ST_SIN_ZZ: begin
				mul_a = {9'd0, z_cur};
				mul_b = {9'd0, z_cur};
			end
			grc_pkg::ST_SIN_T: begin
				mul_a = {9'd0, mul_q[28:14]};
				mul_b = grc_pkg::SIN_C;
			end
			grc_pkg::ST_SIN_U: begin
				mul_a = {9'd0, z2_q};
				mul_b = {9'd0, t_cur};
			end
			grc_pkg::ST_SIN_V: begin
				mul_a = {9'd0, z_q};
				mul_b = {9'd0, u_cur};
			end
			grc_pkg::ST_STEP_X: begin
				mul_a = {{8{ex_q[15]}}, ex_q};
				mul_b = {13'd0, stp};
			end
			grc_pkg::ST_STEP_Y: begin
				mul_a = {{8{ey_q[15]}}, ey_q};
				mul_b = {13'd0, stp};
			end
			grc_pkg::ST_E_XX: begin
				mul_a = {{4{vx_q[19]}}, vx_q};
				mul_b = {{4{vx_q[19]}}, vx_q};
			end
			grc_pkg::ST_E_YY: begin
				mul_a = {{4{vy_q[19]}}, vy_q};
				mul_b = {{4{vy_q[19]}}, vy_q};
			end
			grc_pkg::ST_E_DX: begin
				sq_start = 1'b1;
				mul_a = {{8{ex_q[15]}}, ex_q};
				mul_b = {{4{vx_q[19]}}, vx_q};
			end
			grc_pkg::ST_E_DY: begin
				mul_a = {{8{ey_q[15]}}, ey_q};
				mul_b = {{4{vy_q[19]}}, vy_q};
			end
			grc_pkg::ST_E_CL: begin
				mul_a = {8'd0, ecos_q};
				mul_b = {5'd0, sq_root};
			end
			grc_pkg::ST_WH_DIV: begin
				div_start = 1'b1;
				div_dvd   = {7'd0, h_q, 10'd0};
				div_dvs   = dd;
			end
			grc_pkg::ST_PITCH: begin
				mul_a = {{8{pitch_q[15]}}, pitch_q};
				mul_b = {17'd0, h_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	logic signed [17:0] half_diff;
	logic signed [32:0] num, num_adj;
	logic signed [18:0] top_cur;
	logic [18:0] d1, d2, d3, d4, dep;
	logic signed [37:0] dot4, cl;

	assign half_diff = $signed({12'd0, h_q[6:1]}) - $signed({2'd0, wh_q[16:1]});
	assign num = $signed({half_diff[17], half_diff, 14'd0})
		+ $signed({{11{mul_q[21]}}, mul_q[21:0]});
	assign num_adj = num + (num[32] ? 33'sd16383 : 33'sd0);
	assign top_cur = num_adj[32:14];
	assign d1  = {2'd0, d_q};
	assign d2  = {1'b0, d_q, 1'b0};
	assign d3  = d1 + d2;
	assign d4  = {d_q, 2'b00};
	assign dep = {3'd0, maxd_q};
	assign dot4 = {dot_q, 2'b00};
	assign cl   = {1'b0, mul_q[36:0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= cmd.player_x;
			py_q    <= cmd.player_y;
			view_q  <= cmd.view_angle;
			pitch_q <= pitch_sat;
			col_q   <= cmd.column;
			h_q     <= (sh_q > ROWS7) ? ROWS7 : sh_q;
			edge_q  <= 1'b0;
			y_q     <= '0;
		end
		unique case (state_q)
			grc_pkg::ST_ANG_WAIT: begin
				ang_q   <= view_q - {1'b0, fov_q[15:1]} + div_quo[15:0];
				phase_q <= 1'b0;
			end
			grc_pkg::ST_SIN_ZZ: z_q <= z_cur;
			grc_pkg::ST_SIN_T:  z2_q <= mul_q[28:14];
			grc_pkg::ST_SIN_END: begin
				if (phase_q) begin
					ey_q <= sv_cur;
				end else begin
					ex_q <= sv_cur;
				end
				phase_q <= 1'b1;
			end
			grc_pkg::ST_STEP_Y: dx_q <= mul_q[27:0];
			grc_pkg::ST_INIT: begin
				dy_q <= mul_q[27:0];
				d_q  <= (maxd_q == 16'd0) ? 17'd0 : {6'd0, stp};
				sx_q <= $signed({3'd0, px_q, 14'd0}) + $signed({{5{dx_q[27]}}, dx_q});
				sy_q <= $signed({3'd0, py_q, 14'd0}) + $signed({{5{mul_q[27]}}, mul_q[27:0]});
			end
			grc_pkg::ST_PROBE: begin
				if (oob) begin
					d_q <= {1'b0, maxd_q};
				end
				cx_q <= sx_q[31:24];
				cy_q <= sy_q[31:24];
			end
			grc_pkg::ST_LOOK: begin
				k_q <= 2'd0;
				if (!map_rd && d_q < {1'b0, maxd_q}) begin
					d_q  <= d_q + {6'd0, stp};
					sx_q <= sx_q + $signed({{5{dx_q[27]}}, dx_q});
					sy_q <= sy_q + $signed({{5{dy_q[27]}}, dy_q});
				end
			end
			grc_pkg::ST_E_VEC: begin
				vx_q <= $signed({1'b0, {1'b0, cx_q} + {8'd0, k_q[0]}, 10'd0})
					- $signed({4'd0, px_q});
				vy_q <= $signed({1'b0, {1'b0, cy_q} + {8'd0, k_q[1]}, 10'd0})
					- $signed({4'd0, py_q});
			end
			grc_pkg::ST_E_YY: acc_q <= mul_q[37:0];
			grc_pkg::ST_E_DY: dot_q <= mul_q[35:0];
			grc_pkg::ST_E_DOT: dot_q <= dot_q + mul_q[35:0];
			grc_pkg::ST_E_CMP: begin
				if (dot_q > 36'sd0 && dot4 > cl) begin
					edge_q <= 1'b1;
				end
				k_q <= k_q + 2'd1;
			end
			grc_pkg::ST_WH_WAIT: wh_q <= div_quo[16:0];
			grc_pkg::ST_TOP: begin
				top_q   <= {top_cur[18], top_cur};
				bot_q   <= {top_cur[18], top_cur} + $signed({3'd0, wh_q});
				top13_q <= $signed({{5{top_cur[18]}}, top_cur}) * 24'sd13;
				top4_q  <= $signed({{3{top_cur[18]}}, top_cur, 2'b00});
				if (edge_q) shade_q <= grc_pkg::GL_BLANK;
				else if (d4 <= dep) shade_q <= grc_pkg::GL_FULL;
				else if (d3 < dep) shade_q <= grc_pkg::GL_DARK;
				else if (d2 < dep) shade_q <= grc_pkg::GL_MEDIUM;
				else if (d1 < dep) shade_q <= grc_pkg::GL_LIGHT;
				else shade_q <= grc_pkg::GL_BLANK;
			end
			grc_pkg::ST_EMIT: if (slot_free) y_q <= y_q + 7'd1;
			default: ;
		endcase
	end

	// row glyph
	logic signed [23:0] yv, top24, bot24;
	logic [6:0] e_cur;
	logic [9:0] e8, e4, h10, h3;

	assign yv    = $signed({17'd0, y_q});
	assign top24 = {{4{top_q[19]}}, top_q};
	assign bot24 = {{4{bot_q[19]}}, bot_q};
	assign e_cur = h_q - y_q;
	assign e8    = {e_cur, 3'b000};
	assign e4    = {1'b0, e_cur, 2'b00};
	assign h10   = {3'd0, h_q};
	assign h3    = {3'd0, h_q} + {2'd0, h_q, 1'b0};

	always_comb begin
		if (yv < top24) begin
			if ((yv <<< 1) < top24) glyph_cur = grc_pkg::GL_TILDE;
			else if (yv * 24'sd20 < top13_q) glyph_cur = grc_pkg::GL_DASH;
			else if (yv * 24'sd5 < top4_q) glyph_cur = grc_pkg::GL_DOT;
			else glyph_cur = grc_pkg::GL_BLANK;
		end else if (yv <= bot24) begin
			glyph_cur = shade_q;
		end else begin
			if (e8 < h10) glyph_cur = grc_pkg::GL_HASH;
			else if (e4 < h10) glyph_cur = grc_pkg::GL_CROSS;
			else if (e8 < h3) glyph_cur = grc_pkg::GL_DASH;
			else glyph_cur = grc_pkg::GL_DOT;
		end
	end

	// output register
	assign slot_free = (state_q == grc_pkg::ST_EMIT) && (!out_v_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (slot_free) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			row_q   <= y_q[5:0];
			glyph_q <= glyph_cur;
			last_q  <= (y_q == h_q - 7'd1);
		end
	end

	assign res.valid   = out_v_q;
	assign res.row     = row_q;
	assign res.glyph   = glyph_q;
	assign res.is_last = last_q;
endmodule

// ===== tb/grc_checker.sv =====
// Scoreboard for the grid raycast column renderer: tracks register writes and map
// writes, predicts every glyph of a cast column and compares the glyph channel.
// Depends on grc_pkg and the grc_cmd_if / grc_res_if interfaces.
`timescale 1ns / 1ps

module grc_checker import grc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	grc_cmd_if          cmd,
	grc_res_if          res,
	output int          errors,
	output int          pending
);
	localparam int SIDE = 64;
	localparam int ROWS = 64;

	typedef struct {
		logic [5:0]  row;
		logic [15:0] glyph;
		logic        is_last;
	} glyph_t;

	logic [8:0]  scr_w;
	logic [6:0]  scr_h;
	logic [15:0] fov;
	logic [15:0] depth_lim;
	logic [10:0] step_sz;
	logic [6:0]  map_w;
	logic [6:0]  map_h;
	logic [15:0] edge_cos;
	bit          wall [0:SIDE*SIDE-1];
	glyph_t      glyph_q[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic longint sine_q14(input logic [15:0] a);
		longint q, r, z, z2, t, u, v;
		q = a[15:14];
		r = a[13:0];
		z = q[0] ? 16384 - r : r;
		z2 = (z * z) >>> 14;
		t = 10512 - ((z2 * 1160) >>> 14);
		u = 25736 - ((z2 * t) >>> 14);
		v = (z * u) >>> 14;
		return q[1] ? -v : v;
	endfunction

	function automatic longint root_floor(input longint unsigned x);
		longint unsigned acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= acc + bitv) begin
				x -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else
				acc >>= 1;
			bitv >>= 2;
		end
		return longint'(acc);
	endfunction

	task automatic render_column(input logic [15:0] px16, input logic [15:0] py16,
			input logic [15:0] view, input logic signed [15:0] pit_in,
			input logic [7:0] col);
		longint px, py, ex, ey, sx, sy, vx, vy, dot, len, h, dd, wh, top, bottom;
		longint dep, d, e, pit, w, stp, mw, mh, ang, cx, cy, ecos, fv;
		bit hit, edge_hit;
		logic [15:0] shade, g;
		glyph_t r;
		px = px16;
		py = py16;
		pit = pit_in;
		if (pit > 16384) pit = 16384;
		if (pit < -16384) pit = -16384;
		w = (scr_w == 0) ? 1 : scr_w;
		stp = (step_sz == 0) ? 1 : step_sz;
		mw = (map_w > SIDE) ? SIDE : map_w;
		mh = (map_h > SIDE) ? SIDE : map_h;
		h = (scr_h > ROWS) ? ROWS : scr_h;
		dep = depth_lim;
		ecos = edge_cos;
		fv = fov;
		ang = (longint'(view) - fv / 2 + (fv * longint'(col)) / w) & 64'hFFFF;
		ex = sine_q14(ang[15:0]);
		ey = sine_q14(ang[15:0] + 16'd16384);
		d = 0;
		hit = 0;
		edge_hit = 0;
		while (!hit && d < dep) begin
			d += stp;
			sx = px * 16384 + ex * d;
			sy = py * 16384 + ey * d;
			cx = sx >>> 24;
			cy = sy >>> 24;
			if (sx < 0 || cx >= mw || sy < 0 || cy >= mh) begin
				hit = 1;
				d = dep;
			end else if (wall[int'(cy * SIDE + cx)]) begin
				hit = 1;
				for (int k = 0; k < 4; k++) begin
					vx = (cx + (k & 1)) * 1024 - px;
					vy = (cy + (k >> 1)) * 1024 - py;
					dot = ex * vx + ey * vy;
					len = root_floor(longint'(vx * vx + vy * vy));
					if (dot > 0 && 4 * dot > ecos * len) edge_hit = 1;
				end
			end
		end
		dd = (d != 0) ? d : 1;
		wh = (h * 1024) / dd;
		top = ((h / 2 - wh / 2) * 16384 + pit * h) / 16384;
		bottom = top + wh;
		if (4 * d <= dep) shade = GL_FULL;
		else if (3 * d < dep) shade = GL_DARK;
		else if (2 * d < dep) shade = GL_MEDIUM;
		else if (d < dep) shade = GL_LIGHT;
		else shade = GL_BLANK;
		if (edge_hit) shade = GL_BLANK;
		for (longint y = 0; y < h; y++) begin
			if (y < top) begin
				if (2 * y < top) g = GL_TILDE;
				else if (20 * y < 13 * top) g = GL_DASH;
				else if (5 * y < 4 * top) g = GL_DOT;
				else g = GL_BLANK;
			end else if (y <= bottom) begin
				g = shade;
			end else begin
				e = h - y;
				if (8 * e < h) g = GL_HASH;
				else if (4 * e < h) g = GL_CROSS;
				else if (8 * e < 3 * h) g = GL_DASH;
				else g = GL_DOT;
			end
			r.row = y[5:0];
			r.glyph = g;
			r.is_last = (y == h - 1);
			glyph_q.insert(glyph_q.size(), r);
			pending++;
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w <= RST_SCREEN_WIDTH;
			scr_h <= RST_SCREEN_HEIGHT;
			fov <= RST_FIELD_OF_VIEW;
			depth_lim <= RST_MAX_DEPTH;
			step_sz <= RST_MARCH_STEP;
			map_w <= RST_MAP_WIDTH;
			map_h <= RST_MAP_HEIGHT;
			edge_cos <= RST_EDGE_COSINE;
			for (int i = 0; i < SIDE * SIDE; i++) wall[i] = 0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  scr_w <= cfg_data[8:0];
				CFG_SCREEN_HEIGHT: scr_h <= cfg_data[6:0];
				CFG_FIELD_OF_VIEW: fov <= cfg_data;
				CFG_MAX_DEPTH:     depth_lim <= cfg_data;
				CFG_MARCH_STEP:    step_sz <= cfg_data[10:0];
				CFG_MAP_WIDTH:     map_w <= cfg_data[6:0];
				CFG_MAP_HEIGHT:    map_h <= cfg_data[6:0];
				CFG_EDGE_COSINE:   edge_cos <= cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && cmd.valid && cmd.ready) begin
			if (cmd.opcode == OP_WRITE)
				wall[int'(cmd.cell_y) * SIDE + int'(cmd.cell_x)] = cmd.cell_is_wall;
			else
				render_column(cmd.player_x, cmd.player_y, cmd.view_angle,
					cmd.view_pitch, cmd.column);
		end
		if (arst_n && res.valid && res.ready) begin
			if (glyph_q.size() == 0) begin
				report("unexpected glyph transaction, row", res.row, 0);
			end else begin
				want = glyph_q.pop_front();
				pending--;
				if (res.row !== want.row) report("row", res.row, want.row);
				if (res.glyph !== want.glyph) report("glyph", res.glyph, want.glyph);
				if (res.is_last !== want.is_last)
					report("is_last", res.is_last, want.is_last);
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Top of the grid raycast column renderer bench: clock, reset, register phases,
// command stimulus and glyph back-pressure; verdict comes from grc_checker.
// Depends on grc_pkg, grc_if.sv, the core and tb/grc_checker.sv.
`timescale 1ns / 1ps

module testbench;
	import grc_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int SETTLE = 1000;

	typedef struct {
		logic               opcode;
		logic [15:0]        px;
		logic [15:0]        py;
		logic [15:0]        ang;
		logic signed [15:0] pitch;
		logic [7:0]         col;
		logic [5:0]         cx;
		logic [5:0]         cy;
		logic               wall;
	} cmd_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;
	int          idle_cycles;
	int          hold_req;
	int          hold_left;
	int          stall_left;
	int          cycle_no;
	int          cur_w, cur_h, cur_mw, cur_mh;

	grc_cmd_if cmd ();
	grc_res_if res ();

	grid_raycast_column_renderer_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .res(res)
	);

	grc_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .res(res), .errors(errors), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// glyph side back-pressure: random stalls, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
			stall_left <= 0;
			cycle_no <= 0;
		end else begin
			cycle_no <= cycle_no + 1;
			if (hold_req != 0) begin
				hold_req = 0;
				hold_left <= 2500;
				res.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 15 * ((cycle_no >> 9) % 3)) begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 2);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap(input bit quiet);
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 40) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	task automatic send(input cmd_item_t it, input int gap);
		bit took;
		cmd.valid <= 1'b1;
		cmd.opcode <= it.opcode;
		cmd.player_x <= it.px;
		cmd.player_y <= it.py;
		cmd.view_angle <= it.ang;
		cmd.view_pitch <= it.pitch;
		cmd.column <= it.col;
		cmd.cell_x <= it.cx;
		cmd.cell_y <= it.cy;
		cmd.cell_is_wall <= it.wall;
		do begin
			@(negedge clk);
			took = cmd.ready;
			@(posedge clk);
		end while (!took);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
	endtask

	task automatic load_regs(input int sw, input int sh, input int fv, input int md,
			input int st, input int mw, input int mh, input int ec);
		write_reg(CFG_SCREEN_WIDTH, sw);
		write_reg(CFG_SCREEN_HEIGHT, sh);
		write_reg(CFG_FIELD_OF_VIEW, fv);
		write_reg(CFG_MAX_DEPTH, md);
		write_reg(CFG_MARCH_STEP, st);
		write_reg(CFG_MAP_WIDTH, mw);
		write_reg(CFG_MAP_HEIGHT, mh);
		write_reg(CFG_EDGE_COSINE, ec);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_w = sw & 9'h1FF;
		cur_h = sh & 7'h7F;
		cur_mw = ((mw & 7'h7F) > 64) ? 64 : (mw & 7'h7F);
		cur_mh = ((mh & 7'h7F) > 64) ? 64 : (mh & 7'h7F);
	endtask

	task automatic drain;
		cmd.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic cmd_item_t mk_write(input int x, input int y, input bit w);
		cmd_item_t it;
		it.opcode = OP_WRITE;
		it.px = $urandom;
		it.py = $urandom;
		it.ang = $urandom;
		it.pitch = $urandom;
		it.col = $urandom;
		it.cx = x;
		it.cy = y;
		it.wall = w;
		return it;
	endfunction

	function automatic cmd_item_t mk_cast(input int x, input int y, input int a,
			input int p, input int c);
		cmd_item_t it;
		it = mk_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
		it.opcode = OP_CAST;
		it.px = x;
		it.py = y;
		it.ang = a;
		it.pitch = p;
		it.col = c;
		return it;
	endfunction

	function automatic cmd_item_t rand_item(input bit build);
		int mw, mh, w;
		mw = (cur_mw == 0) ? 1 : cur_mw;
		mh = (cur_mh == 0) ? 1 : cur_mh;
		w = (cur_w == 0) ? 1 : ((cur_w > 256) ? 256 : cur_w);
		if (build || $urandom_range(0, 99) < 15)
			return mk_write(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, mw - 1),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, mh - 1), $urandom_range(0, 3) != 0);
		return mk_cast(
			($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, mw * 1024 - 1),
			($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, mh * 1024 - 1),
			$urandom_range(0, 65535),
			($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 32768) - 16384,
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, w - 1));
	endfunction

	task automatic run_random(input int n, input bit quiet, input bit squeeze);
		for (int i = 0; i < n; i++) begin
			if (squeeze && i == 14) hold_req = 1;
			send(rand_item(i < 12), pick_gap(quiet));
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data = '0;
		cmd.valid = 1'b0;
		cmd.opcode = OP_WRITE;
		cmd.player_x = '0;
		cmd.player_y = '0;
		cmd.view_angle = '0;
		cmd.view_pitch = '0;
		cmd.column = '0;
		cmd.cell_x = '0;
		cmd.cell_y = '0;
		cmd.cell_is_wall = 1'b0;
		hold_req = 0;
		idle_cycles = 0;
		cur_w = RST_SCREEN_WIDTH;
		cur_h = RST_SCREEN_HEIGHT;
		cur_mw = RST_MAP_WIDTH;
		cur_mh = RST_MAP_HEIGHT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of cells, pitch, column, position and angle
		send(mk_write(63, 63, 1), 0);
		send(mk_write(0, 0, 1), 1);
		send(mk_write(0, 0, 0), 0);
		send(mk_write(2, 5, 1), 0);
		send(mk_write(3, 5, 1), 2);
		send(mk_write(5, 2, 1), 0);
		send(mk_cast(2560, 2560, 0, 0, 60), 0);
		send(mk_cast(2560, 2560, 0, 16384, 60), 0);
		send(mk_cast(2560, 2560, 0, -16384, 60), 3);
		send(mk_cast(2560, 2560, 0, 32767, 60), 0);
		send(mk_cast(2560, 2560, 0, -32768, 60), 0);
		send(mk_cast(2560, 2560, 16384, 0, 0), 0);
		send(mk_cast(2560, 2560, 65535, 0, 119), 1);
		send(mk_cast(2560, 2560, 32768, 0, 255), 0);
		send(mk_cast(0, 0, 0, 0, 60), 0);
		send(mk_cast(65535, 65535, 40000, 0, 60), 0);
		send(mk_cast(3072, 4096, 0, 0, 60), 0);
		send(mk_cast(2048, 2048, 8192, 0, 60), 0);
		send(mk_cast(1500, 700, 49152, 500, 10), 0);
		drain();

		run_random(70, 0, 1);
		load_regs(256, 64, 65535, 65535, 1024, 64, 64, 65535);
		run_random(70, 1, 0);
		load_regs(0, 127, 0, 300, 0, 127, 127, 0);
		run_random(60, 0, 0);
		load_regs(511, 1, 32768, 0, 2047, 1, 1, 40000);
		run_random(50, 0, 0);
		load_regs(37, 23, 12000, 8000, 40, 20, 30, 60000);
		run_random(70, 0, 0);
		load_regs(80, 0, 16384, 6000, 64, 40, 40, 65000);
		run_random(40, 0, 0);
		load_regs(120, 64, 8192, 20000, 128, 64, 64, 65533);
		run_random(80, 0, 0);

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
